// ===== sv/lps_pkg.sv =====
// Shared types, register indexes and the bit-expansion function for the LED pulse encoder.
package lps_pkg;

	localparam int DATA_W     = 8;
	localparam int RLEN_W     = 6;
	localparam int PAT_W      = 80;
	localparam int BYTES_MODE0 = 5;
	localparam int BYTES_MODE1 = 10;

	localparam logic REG_CHIP_MODE    = 1'b0;
	localparam logic REG_RESET_LENGTH = 1'b1;

	// One accepted item after framing: data byte, error flag and reset tail length.
	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic              err;
		logic [RLEN_W-1:0] tail;
	} lps_item_t;

	// Expand a data byte, MSB first, into the pulse pattern, left aligned in 80 bits.
	function automatic logic [PAT_W-1:0] lps_expand(input logic [DATA_W-1:0] data,
			input logic mode);
		logic [PAT_W-1:0] p;
		p = '0;
		for (int i = 0; i < DATA_W; i++) begin
			if (mode) begin
				p[PAT_W-1-10*i -: 10] = {2'b11, {6{data[DATA_W-1-i]}}, 2'b00};
			end else begin
				p[PAT_W-1-5*i -: 5] = {2'b11, data[DATA_W-1-i], 2'b00};
			end
		end
		return p;
	endfunction

endpackage

// ===== sv/lps_frame_ctl.sv =====
// Input register, pixel byte phase and reset tail decision for each incoming item.
module lps_frame_ctl import lps_pkg::*; #(
	parameter int MAX_RESET_BYTES = 48
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,
	input  logic              s_tlast,
	input  logic [RLEN_W-1:0] reset_length,
	input  logic              take,
	output logic              item_valid,
	output lps_item_t         item
);

	logic [1:0]        phase_q;
	logic [1:0]        next_phase;
	logic              valid_s1;
	lps_item_t         item_s1;
	logic              accept;
	logic [RLEN_W-1:0] tail_clamped;

	assign accept       = s_tvalid && s_tready;
	assign s_tready     = !valid_s1 || take;
	assign next_phase   = (phase_q >= 2'd2) ? 2'd0 : phase_q + 2'd1;
	assign tail_clamped = (reset_length > RLEN_W'(MAX_RESET_BYTES)) ?
		RLEN_W'(MAX_RESET_BYTES) : reset_length;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= 2'd0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				phase_q  <= s_tlast ? 2'd0 : next_phase;
				valid_s1 <= 1'b1;
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.data <= s_tdata;
			// misaligned frame end: no tail, error on the final byte
			item_s1.err  <= s_tlast && (next_phase != 2'd0);
			item_s1.tail <= (s_tlast && (next_phase == 2'd0)) ? tail_clamped : '0;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3) else $error("phase reached unused code");
	a_frame_end_phase: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tlast |=> phase_q == 2'd0) else $error("phase not cleared at frame end");
	a_hold_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !take |=> valid_s1 && $stable(item_s1))
		else $error("pending item lost");

endmodule

// ===== sv/lps_serializer.sv =====
// Pattern shift register and byte counter that emit one SPI byte per cycle while m_tready is high.
module lps_serializer import lps_pkg::*; #(
	parameter int MAX_RESET_BYTES = 48
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              chip_mode,
	input  logic              item_valid,
	input  lps_item_t         item,
	output logic              take,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,
	output logic              m_tlast,
	output logic              m_tuser
);

	localparam int CNT_W = $clog2(MAX_RESET_BYTES + BYTES_MODE1 + 1);

	logic [PAT_W-1:0] pat_q;
	logic [CNT_W-1:0] rem_q;
	logic             err_q;
	logic             busy_q;
	logic             final_byte;
	logic             out_accept;
	logic [CNT_W-1:0] pat_bytes;

	assign final_byte = (rem_q == CNT_W'(1));
	assign out_accept = m_tvalid && m_tready;
	assign take       = item_valid && (!busy_q || (m_tready && final_byte));
	assign pat_bytes  = chip_mode ? CNT_W'(BYTES_MODE1) : CNT_W'(BYTES_MODE0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rem_q  <= '0;
		end else begin
			if (take) begin
				busy_q <= 1'b1;
				rem_q  <= pat_bytes + CNT_W'(item.tail);
			end else if (out_accept) begin
				busy_q <= !final_byte;
				rem_q  <= rem_q - CNT_W'(1);
			end
		end
	end

	// after the pattern is shifted out the register holds zeros: the reset tail
	always_ff @(posedge clk) begin
		if (take) begin
			pat_q <= lps_expand(item.data, chip_mode);
			err_q <= item.err;
		end else if (out_accept) begin
			pat_q <= {pat_q[PAT_W-DATA_W-1:0], {DATA_W{1'b0}}};
		end
	end

	assign m_tvalid = busy_q;
	assign m_tdata  = pat_q[PAT_W-1 -: DATA_W];
	assign m_tlast  = final_byte;
	assign m_tuser  = err_q && final_byte;

	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q != '0) else $error("busy with empty count");
	a_take_final: assert property (@(posedge clk) disable iff (!arst_n)
		take && busy_q |-> m_tready && final_byte) else $error("item loaded mid run");
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast) else $error("error flag before final byte");

endmodule

// ===== sv/led_pulse_spi_encoder.sv =====
// Top level of the addressable-LED SPI bit expander: config registers and item path.
// Each accepted data byte yields 5 SPI bytes (chip_mode 0) or 10 (chip_mode 1), plus on an
// aligned frame end min(reset_length, MAX_RESET_BYTES) zero bytes; the final byte of each run
// carries m_tlast, and m_tuser flags a frame end that is not a whole number of 3-byte pixels.
// The output serializer emits one SPI byte per cycle while m_tready is high; a run is 5 to
// 10 + MAX_RESET_BYTES bytes. One further item is held in the input register meanwhile, and
// a queued item starts on the cycle after the previous run's final byte is taken, so runs
// stream without gaps. Configuration is taken at any time (cfg_ready is always high) and
// should change only while the block is idle.
module led_pulse_spi_encoder import lps_pkg::*; #(
	parameter int MAX_RESET_BYTES = 48
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // [7:0] data_byte
	input  logic              s_tlast,   // frame_last
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,   // [7:0] spi_byte
	output logic              m_tlast,   // run_last
	output logic              m_tuser,   // [0] frame_error
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_addr,
	input  logic [RLEN_W-1:0] cfg_data
);

	logic              chip_mode_q;
	logic [RLEN_W-1:0] reset_length_q;
	logic              item_valid;
	lps_item_t         item;
	logic              take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_mode_q    <= 1'b0;
			reset_length_q <= RLEN_W'(26);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_addr)
				REG_CHIP_MODE:    chip_mode_q    <= cfg_data[0];
				REG_RESET_LENGTH: reset_length_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	lps_frame_ctl #(
		.MAX_RESET_BYTES(MAX_RESET_BYTES)
	) u_frame_ctl (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.reset_length(reset_length_q),
		.take        (take),
		.item_valid  (item_valid),
		.item        (item)
	);

	lps_serializer #(
		.MAX_RESET_BYTES(MAX_RESET_BYTES)
	) u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.chip_mode (chip_mode_q),
		.item_valid(item_valid),
		.item      (item),
		.take      (take),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule

// ===== tb/led_spi_expect_pkg.sv =====
// Expected-result tracker for the LED pulse SPI encoder: pulse expansion, reset tail, pixel phase.
package led_spi_expect_pkg;
	import lps_pkg::*;

	typedef struct {
		logic [DATA_W-1:0] spi_byte;
		logic              run_last;
		logic              frame_error;
	} spi_result_t;

	class spi_pattern_tracker;
		bit              chip_mode;
		bit [RLEN_W-1:0] reset_len;
		bit [1:0]        pixel_phase;
		int              tail_cap;
		spi_result_t     expected_spi[$];

		function new(int cap);
			tail_cap    = cap;
			chip_mode   = 1'b0;
			reset_len   = 6'd26;
			pixel_phase = 2'd0;
		endfunction

		function void set_reg(logic addr, logic [RLEN_W-1:0] val);
			if (addr == REG_CHIP_MODE) begin
				chip_mode = val[0];
			end else begin
				reset_len = val;
			end
		endfunction

		// Accepted colour byte: queue its pattern bytes and any reset tail.
		function void note_colour_byte(logic [DATA_W-1:0] data, logic frame_last);
			logic [79:0] acc;
			logic [1:0]  nxt;
			int          nbytes;
			int          tail;
			int          total;
			bit          err;
			spi_result_t r;
			acc = '0;
			for (int i = DATA_W - 1; i >= 0; i--) begin
				if (chip_mode) begin
					acc = {acc[69:0], 2'b11, {6{data[i]}}, 2'b00};
				end else begin
					acc = {acc[74:0], 2'b11, data[i], 2'b00};
				end
			end
			nbytes = chip_mode ? 10 : 5;
			// phase code 3 never occurs but wraps like 2
			nxt = (pixel_phase >= 2'd2) ? 2'd0 : pixel_phase + 2'd1;
			tail = 0;
			err = 1'b0;
			if (frame_last) begin
				if (nxt != 2'd0) begin
					err = 1'b1;
				end else begin
					tail = (reset_len > tail_cap) ? tail_cap : reset_len;
				end
				pixel_phase = 2'd0;
			end else begin
				pixel_phase = nxt;
			end
			total = nbytes + tail;
			for (int k = 0; k < total; k++) begin
				r.spi_byte    = (k < nbytes) ? acc[nbytes*8-1-8*k -: 8] : 8'h00;
				r.run_last    = (k == total - 1);
				r.frame_error = r.run_last & err;
				expected_spi.push_back(r);
			end
		endfunction

		// Empty string when the SPI byte matches the oldest expectation.
		function string check_spi_byte(logic [DATA_W-1:0] spi, logic last, logic err);
			spi_result_t r;
			if (expected_spi.size() == 0) begin
				return $sformatf("unexpected spi byte %02h last %0b err %0b", spi, last, err);
			end
			r = expected_spi.pop_front();
			if (spi !== r.spi_byte || last !== r.run_last || err !== r.frame_error) begin
				return $sformatf("spi byte %02h last %0b err %0b, wanted %02h %0b %0b",
					spi, last, err, r.spi_byte, r.run_last, r.frame_error);
			end
			return "";
		endfunction

		function int pending();
			return expected_spi.size();
		endfunction
	endclass

endpackage

// ===== tb/tb_led_pulse_spi_encoder.sv =====
// Testbench top for the LED pulse SPI encoder: stimulus, random stalls and result checks.
module tb_led_pulse_spi_encoder;
	import lps_pkg::*;
	import led_spi_expect_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TAIL_CAP = 48;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata;   // [7:0] data_byte
	logic              s_tlast;   // frame_last
	logic              m_tvalid;
	logic              m_tready;
	logic [DATA_W-1:0] m_tdata;   // [7:0] spi_byte
	logic              m_tlast;   // run_last
	logic              m_tuser;   // [0] frame_error
	logic              cfg_valid;
	logic              cfg_ready;
	logic              cfg_addr;
	logic [RLEN_W-1:0] cfg_data;

	spi_pattern_tracker tracker;
	int                 mismatches = 0;
	bit                 no_stall = 1'b0;
	int                 ready_hold = 0;
	string              msg;

	led_pulse_spi_encoder #(.MAX_RESET_BYTES(TAIL_CAP)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// mostly short gaps, now and then a long one
	function int pick_gap();
		int r;
		if (no_stall) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	task report_mismatch(input string text);
		$display("MISMATCH at %0t: %s", $realtime, text);
		mismatches++;
	endtask

	task write_reg(input logic addr, input logic [RLEN_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_addr  <= addr;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_reg(addr, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task set_config(input bit mode, input logic [RLEN_W-1:0] rlen);
		write_reg(REG_CHIP_MODE, {5'd0, mode});
		write_reg(REG_RESET_LENGTH, rlen);
	endtask

	// tvalid stays high after acceptance so back-to-back items need no re-raise
	task send_item(input logic [DATA_W-1:0] data, input logic last);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		tracker.note_colour_byte(data, last);
	endtask

	task finish_phase();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task run_random_phase(input int n_items);
		int  sent;
		int  len;
		bit  broken;
		sent = 0;
		while (sent < n_items) begin
			broken = ($urandom_range(0, 4) == 0);
			len = broken ? $urandom_range(1, 8) : 3 * $urandom_range(1, 4);
			for (int i = 0; i < len; i++) begin
				send_item(DATA_W'($urandom_range(0, 255)), i == len - 1);
				sent++;
			end
		end
	endtask

	always @(negedge clk) begin
		if (ready_hold > 0) begin
			m_tready <= 1'b0;
			ready_hold--;
		end else begin
			m_tready <= 1'b1;
			ready_hold = pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			msg = tracker.check_spi_byte(m_tdata, m_tlast, m_tuser);
			if (msg != "") begin
				report_mismatch(msg);
			end
		end
	end

	initial begin
		logic [RLEN_W-1:0] rlen;
		tracker   = new(TAIL_CAP);
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		cfg_valid = 1'b0;
		cfg_addr  = 1'b0;
		cfg_data  = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		// reset configuration, aligned frame
		send_item(8'h12, 1'b0);
		send_item(8'h34, 1'b0);
		send_item(8'h56, 1'b1);
		finish_phase();

		// zero reset length, then a one-byte misaligned frame
		set_config(1'b0, 6'd0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h80, 1'b1);
		send_item(8'h01, 1'b1);
		finish_phase();

		// long mode, reset length beyond the cap saturates; then a two-byte frame
		set_config(1'b1, 6'd63);
		send_item(8'hAA, 1'b0);
		send_item(8'h55, 1'b0);
		send_item(8'h01, 1'b1);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b1);
		finish_phase();

		// short mode, reset length exactly at the cap, two pixels
		no_stall = 1'b1;
		set_config(1'b0, TAIL_CAP[RLEN_W-1:0]);
		send_item(8'h5A, 1'b0);
		send_item(8'hA5, 1'b0);
		send_item(8'hC3, 1'b0);
		send_item(8'h3C, 1'b0);
		send_item(8'h0F, 1'b0);
		send_item(8'hF0, 1'b1);
		finish_phase();

		for (int p = 0; p < 10; p++) begin
			no_stall = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 5))
				0: rlen = 6'd0;
				1: rlen = TAIL_CAP[RLEN_W-1:0];
				2: rlen = 6'd63;
				3: rlen = RLEN_W'($urandom_range(0, 63));
				default: rlen = RLEN_W'($urandom_range(0, 12));
			endcase
			set_config(1'($urandom_range(0, 1)), rlen);
			run_random_phase(30);
			finish_phase();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0 && tracker.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// worst case: ~350 items x 58 bytes, each behind the longest ready stall, well under this bound
	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
